// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- design/sxp_pkg.sv -----
package sxp_pkg;

    localparam int PARAM_BITS = 16;
    localparam int MAX_PARAMS = 5;
    localparam int CNT_W      = $clog2(MAX_PARAMS + 2);
    localparam int IDX_W      = $clog2(MAX_PARAMS);
    localparam int RES_W      = 16;
    localparam int FIFO_DEPTH = 3;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [PARAM_BITS-1:0] PARAM_LIMIT = {PARAM_BITS{1'b1}};

    typedef enum logic [2:0] {
        EV_RENDER    = 3'd0,
        EV_REWIND    = 3'd1,
        EV_NEWLINE   = 3'd2,
        EV_USE_COLOR = 3'd3,
        EV_SET_COLOR = 3'd4,
        EV_RASTER    = 3'd5,
        EV_FINISHED  = 3'd6
    } t_event;

    typedef struct packed {
        t_event            event_res;
        logic [5:0]        sixel_bits;
        logic [RES_W-1:0]  repeat_count;
        logic [RES_W-1:0]  color_index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [RES_W-1:0]  aspect_numerator;
        logic [RES_W-1:0]  aspect_denominator;
        logic [RES_W-1:0]  image_width;
        logic [RES_W-1:0]  image_height;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        t_result first;
        t_result second;
    } t_emit;

    typedef struct packed {
        logic              room;
        logic [FCNT_W-1:0] count;
    } t_fifo_status;

endpackage

// ----- design/sxp_if.sv -----
interface sxp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, kind, byte_value, input ready);
    modport sink (input valid, kind, byte_value, output ready);
endinterface

interface sxp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [5:0]  sixel_bits;
    logic [15:0] repeat_count;
    logic [15:0] color_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] aspect_numerator;
    logic [15:0] aspect_denominator;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;

    modport source (
        output valid, event_res, sixel_bits, repeat_count, color_index, red, green, blue,
               aspect_numerator, aspect_denominator, image_width, image_height, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, sixel_bits, repeat_count, color_index, red, green, blue,
               aspect_numerator, aspect_denominator, image_width, image_height, last,
        output ready
    );
endinterface

// ----- design/sxp_parser.sv -----
module sxp_parser import sxp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    output t_emit      o_emit
);

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] SIXEL_LO  = 8'd63;
    localparam logic [7:0] SIXEL_HI  = 8'd126;

    localparam int RGB_SPACE           = 2;
    localparam int COLOR_SELECT_PARAMS = 1;
    localparam int COLOR_DEFINE_PARAMS = 5;
    localparam int RASTER_PARAMS       = 4;

    localparam int ACC_W       = PARAM_BITS + 4;
    localparam int SCALE_SHIFT = PARAM_BITS + 6;
    localparam int PROD_W      = ACC_W + SCALE_SHIFT;
    localparam logic [SCALE_SHIFT-1:0] SCALE_RECIP =
        SCALE_SHIFT'(((64'd1 << SCALE_SHIFT) + 64'd4) / 64'd5);

    typedef enum logic [2:0] {
        M_GROUND = 3'd0,
        M_REPEAT = 3'd1,
        M_CINTRO = 3'd2,
        M_CPARAM = 3'd3,
        M_RASTER = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        A_NONE,
        A_DIGIT,
        A_OPEN,
        A_INTRO
    } t_action;

    // floor(v * 255 / 100) = floor(floor(51 * v / 4) / 5), low 8 bits
    function automatic logic [7:0] scale_pct(input logic [PARAM_BITS-1:0] v);
        logic [PARAM_BITS+5:0] x51;
        logic [ACC_W-1:0]      quarter;
        logic [PROD_W-1:0]     prod;
        x51 = ((PARAM_BITS + 6)'(v) << 5) + ((PARAM_BITS + 6)'(v) << 4)
            + ((PARAM_BITS + 6)'(v) << 1) + (PARAM_BITS + 6)'(v);
        quarter = x51[PARAM_BITS+5:2];
        prod = PROD_W'(quarter) * PROD_W'(SCALE_RECIP);
        return prod[SCALE_SHIFT +: 8];
    endfunction

    function automatic t_result mk_simple(input t_event ev, input logic [5:0] bits,
                                          input logic [RES_W-1:0] rep);
        t_result r;
        r = '0;
        r.event_res    = ev;
        r.sixel_bits   = bits;
        r.repeat_count = rep;
        return r;
    endfunction

    t_mode                 r_mode;
    logic [CNT_W-1:0]      r_count;
    logic [PARAM_BITS-1:0] r_pv [MAX_PARAMS];
    logic [7:0]            r_sc [MAX_PARAMS];

    t_mode                 n_mode;
    t_action               act;
    logic                  digit;
    logic                  sixel;
    logic [7:0]            digit_off;
    logic [7:0]            sixel_off;
    logic [IDX_W-1:0]      k;
    logic                  in_range;
    logic [PARAM_BITS-1:0] cur;
    logic [ACC_W-1:0]      acc;
    logic [PARAM_BITS-1:0] digit_v;
    logic [7:0]            digit_sc;
    logic                  leave_valid;
    t_result               leave_res;
    logic                  do_leave;
    logic                  other;
    logic                  own_valid;
    t_result               own_res;
    logic                  lv;

    assign digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign sixel     = (i_byte >= SIXEL_LO) && (i_byte <= SIXEL_HI);
    assign digit_off = i_byte - CH_ZERO;
    assign sixel_off = i_byte - SIXEL_LO;
    assign k         = IDX_W'(r_count - CNT_W'(1));
    assign in_range  = (r_count != '0) && (r_count <= CNT_W'(MAX_PARAMS));

    always_comb begin
        cur = '0;
        for (int i = 0; i < MAX_PARAMS; i++) begin
            if (IDX_W'(i) == k) begin
                cur = r_pv[i];
            end
        end
    end

    always_comb begin
        acc = (ACC_W'(cur) << 3) + (ACC_W'(cur) << 1) + ACC_W'(digit_off[3:0]);
        digit_v  = (acc > ACC_W'(PARAM_LIMIT)) ? PARAM_LIMIT : acc[PARAM_BITS-1:0];
        digit_sc = scale_pct(digit_v);
    end

    always_comb begin
        leave_valid = 1'b0;
        leave_res   = '0;
        if (r_mode == M_CPARAM) begin
            if (r_count == CNT_W'(COLOR_SELECT_PARAMS)) begin
                leave_valid           = 1'b1;
                leave_res.event_res   = EV_USE_COLOR;
                leave_res.color_index = RES_W'(r_pv[0]);
            end else if (r_count == CNT_W'(COLOR_DEFINE_PARAMS)
                         && r_pv[1] == PARAM_BITS'(RGB_SPACE)) begin
                leave_valid           = 1'b1;
                leave_res.event_res   = EV_SET_COLOR;
                leave_res.color_index = RES_W'(r_pv[0]);
                leave_res.red         = r_sc[2];
                leave_res.green       = r_sc[3];
                leave_res.blue        = r_sc[4];
            end
        end else if (r_mode == M_RASTER) begin
            if (r_count == CNT_W'(RASTER_PARAMS)) begin
                leave_valid                  = 1'b1;
                leave_res.event_res          = EV_RASTER;
                leave_res.aspect_numerator   = RES_W'(r_pv[0]);
                leave_res.aspect_denominator = RES_W'(r_pv[1]);
                leave_res.image_width        = RES_W'(r_pv[2]);
                leave_res.image_height       = RES_W'(r_pv[3]);
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        act       = A_NONE;
        do_leave  = 1'b0;
        other     = 1'b0;
        own_valid = 1'b0;
        own_res   = mk_simple(EV_RENDER, 6'd0, '0);
        if (i_kind) begin
            do_leave  = 1'b1;
            n_mode    = M_GROUND;
            own_valid = 1'b1;
            own_res   = mk_simple(EV_FINISHED, 6'd0, '0);
        end else begin
            unique case (r_mode)
                M_REPEAT: begin
                    if (digit) begin
                        act = A_DIGIT;
                    end else if (sixel) begin
                        own_valid = (r_pv[0] != '0);
                        own_res   = mk_simple(EV_RENDER, sixel_off[5:0], RES_W'(r_pv[0]));
                        n_mode    = M_GROUND;
                    end else begin
                        other = 1'b1;
                    end
                end
                M_CINTRO: begin
                    if (digit) begin
                        act    = A_DIGIT;
                        n_mode = M_CPARAM;
                    end else begin
                        other = 1'b1;
                    end
                end
                M_CPARAM, M_RASTER: begin
                    if (digit) begin
                        act = A_DIGIT;
                    end else if (i_byte == CH_SEMI) begin
                        act = A_OPEN;
                    end else begin
                        other = 1'b1;
                    end
                end
                default: begin
                    other = 1'b1;
                end
            endcase
            if (other) begin
                do_leave = 1'b1;
                unique case (i_byte)
                    CH_HASH: begin
                        n_mode = M_CINTRO;
                        act    = A_INTRO;
                    end
                    CH_BANG: begin
                        n_mode = M_REPEAT;
                        act    = A_INTRO;
                    end
                    CH_QUOTE: begin
                        n_mode = M_RASTER;
                        act    = A_INTRO;
                    end
                    CH_DOLLAR: begin
                        n_mode    = M_GROUND;
                        own_valid = 1'b1;
                        own_res   = mk_simple(EV_REWIND, 6'd0, '0);
                    end
                    CH_MINUS: begin
                        n_mode    = M_GROUND;
                        own_valid = 1'b1;
                        own_res   = mk_simple(EV_NEWLINE, 6'd0, '0);
                    end
                    default: begin
                        n_mode    = M_GROUND;
                        own_valid = sixel;
                        own_res   = mk_simple(EV_RENDER, sixel_off[5:0], RES_W'(1));
                    end
                endcase
            end
        end
    end

    // Put a leaving event ahead of the byte's own event.
    always_comb begin
        lv                  = do_leave && leave_valid;
        o_emit.first_valid  = lv || own_valid;
        o_emit.second_valid = lv && own_valid;
        o_emit.first        = lv ? leave_res : own_res;
        o_emit.first.last   = !(lv && own_valid);
        o_emit.second       = own_res;
        o_emit.second.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_GROUND;
            r_count <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            unique case (act)
                A_OPEN: begin
                    r_count <= (r_count < CNT_W'(MAX_PARAMS)) ? r_count + CNT_W'(1)
                                                              : CNT_W'(MAX_PARAMS + 1);
                end
                A_INTRO: begin
                    r_count <= CNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            unique case (act)
                A_DIGIT: begin
                    if (in_range) begin
                        r_pv[k] <= digit_v;
                        r_sc[k] <= digit_sc;
                    end
                end
                A_OPEN: begin
                    if (r_count < CNT_W'(MAX_PARAMS)) begin
                        r_pv[IDX_W'(r_count)] <= '0;
                        r_sc[IDX_W'(r_count)] <= '0;
                    end
                end
                A_INTRO: begin
                    r_pv[0] <= '0;
                    r_sc[0] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- design/sxp_result_fifo.sv -----
module sxp_result_fifo import sxp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_emit        i_emit,
    input  logic         i_pop,
    output t_result      o_head,
    output logic         o_valid,
    output t_fifo_status o_status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    t_result           r_q [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FCNT_W-1:0] r_count;

    logic              wr0;
    logic              wr1;
    logic              pop;
    logic [PTR_W-1:0]  n_wp;
    logic [FCNT_W-1:0] n_count;

    assign wr0     = i_push && i_emit.first_valid;
    assign wr1     = i_push && i_emit.second_valid;
    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;
    assign n_wp    = wr1 ? ptr_inc(ptr_inc(r_wp)) : (wr0 ? ptr_inc(r_wp) : r_wp);
    assign n_count = r_count + FCNT_W'(wr0) + FCNT_W'(wr1) - FCNT_W'(pop);

    assign o_head          = r_q[r_rp];
    assign o_status.count  = r_count;
    assign o_status.room   = (r_count <= FCNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_count <= n_count;
            if (pop) begin
                r_rp <= ptr_inc(r_rp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_q[r_wp] <= i_emit.first;
        end
        if (wr1) begin
            r_q[ptr_inc(r_wp)] <= i_emit.second;
        end
    end

endmodule

// ----- design/sixel_stream_parser_top.sv -----
// Sixel stream parser: takes one stream byte or end-of-image mark per input
// transaction and returns the drawing events it causes (render with repeat
// count, rewind, newline, select color, define RGB color, raster attributes,
// finished), at most two per byte, the last one flagged. A byte is parsed
// combinationally from the input register; events wait in a three-entry
// queue, and bytes flow at one per cycle while it has room. Input ready drops
// while the input register is full and the queue holds more than one event;
// a byte that closes a color or raster sequence and also yields its own event
// therefore stalls the input when the consumer takes one event per cycle.
`include "assert_macros.svh"

module sixel_stream_parser_top import sxp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sxp_in_if.sink      i_in,
    sxp_out_if.source   o_out
);

    logic         r_in_valid;
    logic         r_kind;
    logic [7:0]   r_byte;

    logic         in_ready;
    logic         accept;
    logic         fire;
    t_emit        emit;
    t_result      head;
    logic         head_valid;
    t_fifo_status fifo_st;

    assign in_ready   = !r_in_valid || fifo_st.room;
    assign accept     = i_in.valid && in_ready;
    assign fire       = r_in_valid && fifo_st.room;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the byte until the parser takes it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.byte_value;
        end
    end

    sxp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (r_kind),
        .i_byte  (r_byte),
        .o_emit  (emit)
    );

    sxp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_emit   (emit),
        .i_pop    (o_out.ready),
        .o_head   (head),
        .o_valid  (head_valid),
        .o_status (fifo_st)
    );

    assign o_out.valid              = head_valid;
    assign o_out.event_res          = head.event_res;
    assign o_out.sixel_bits         = head.sixel_bits;
    assign o_out.repeat_count       = head.repeat_count;
    assign o_out.color_index        = head.color_index;
    assign o_out.red                = head.red;
    assign o_out.green              = head.green;
    assign o_out.blue               = head.blue;
    assign o_out.aspect_numerator   = head.aspect_numerator;
    assign o_out.aspect_denominator = head.aspect_denominator;
    assign o_out.image_width        = head.image_width;
    assign o_out.image_height       = head.image_height;
    assign o_out.last               = head.last;

    `ASSERT_HOLDS(a_in_hold, i_clk, i_rst_n, r_in_valid && !fire |=> r_in_valid)
    `ASSERT_NEVER(a_pair_queued, i_clk, i_rst_n, o_out.valid && !o_out.last && fifo_st.count < FCNT_W'(2))

endmodule

// ----- sim/sixel_tb_pkg.sv -----
`timescale 1ns / 1ps

package sixel_tb_pkg;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_REPEAT   = 8'h21;
    localparam logic [7:0] CH_RASTER   = 8'h22;
    localparam logic [7:0] CH_COLOR    = 8'h23;
    localparam logic [7:0] CH_REWIND   = 8'h24;
    localparam logic [7:0] CH_NEWLINE  = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] SIXEL_FIRST = 8'h3F;
    localparam logic [7:0] SIXEL_LAST  = 8'h7E;

    localparam int COLOR_SPACE_RGB    = 2;
    localparam int RGB_PARAM_COUNT    = 5;
    localparam int RASTER_PARAM_COUNT = 4;
    localparam int RGB_SCALE          = 255;
    localparam int PERCENT_SCALE      = 100;

endpackage

// ----- sim/sixel_stream_parser_checker.sv -----
`timescale 1ns / 1ps

module sixel_stream_parser_checker
    import sxp_pkg::*;
    import sixel_tb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sxp_in_if    i_in,
    sxp_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef enum logic [2:0] {
        PS_GROUND,
        PS_REPEAT,
        PS_COLOR_INTRO,
        PS_COLOR_PARAMS,
        PS_RASTER
    } t_parse_state;

    t_parse_state          parse_state;
    logic [PARAM_BITS-1:0] params [MAX_PARAMS];
    logic [CNT_W-1:0]      param_cnt;

    t_result step_events[$];
    t_result expected_events[$];
    int      fail_total = 0;
    int      checked_total = 0;

    function automatic void emit_event(t_result r);
        if (step_events.size() < 2) begin
            step_events.insert(step_events.size(), r);
        end
    endfunction

    function automatic t_result blank_event(t_event ev);
        t_result r;
        r = '0;
        r.event_res = ev;
        return r;
    endfunction

    function automatic void emit_render(logic [7:0] b, logic [PARAM_BITS-1:0] count);
        t_result r;
        r = blank_event(EV_RENDER);
        r.sixel_bits = 6'(b - SIXEL_FIRST);
        r.repeat_count = RES_W'(count);
        emit_event(r);
    endfunction

    function automatic logic [7:0] scale_percent(logic [PARAM_BITS-1:0] v);
        logic [31:0] s;
        s = 32'(v) * 32'(RGB_SCALE) / 32'(PERCENT_SCALE);
        return s[7:0];
    endfunction

    function automatic void close_sequence();
        t_result r;
        if (parse_state == PS_COLOR_PARAMS) begin
            if (param_cnt == CNT_W'(1)) begin
                r = blank_event(EV_USE_COLOR);
                r.color_index = RES_W'(params[0]);
                emit_event(r);
            end else if (param_cnt == CNT_W'(RGB_PARAM_COUNT)
                         && params[1] == PARAM_BITS'(COLOR_SPACE_RGB)) begin
                r = blank_event(EV_SET_COLOR);
                r.color_index = RES_W'(params[0]);
                r.red = scale_percent(params[2]);
                r.green = scale_percent(params[3]);
                r.blue = scale_percent(params[4]);
                emit_event(r);
            end
        end else if (parse_state == PS_RASTER && param_cnt == CNT_W'(RASTER_PARAM_COUNT)) begin
            r = blank_event(EV_RASTER);
            r.aspect_numerator = RES_W'(params[0]);
            r.aspect_denominator = RES_W'(params[1]);
            r.image_width = RES_W'(params[2]);
            r.image_height = RES_W'(params[3]);
            emit_event(r);
        end
    endfunction

    function automatic void enter_state(t_parse_state s);
        close_sequence();
        parse_state = s;
        if (s == PS_REPEAT || s == PS_COLOR_INTRO || s == PS_RASTER) begin
            params[0] = '0;
            param_cnt = CNT_W'(1);
        end
    endfunction

    function automatic void add_digit(logic [7:0] b);
        logic [31:0]      v;
        logic [IDX_W-1:0] idx;
        if (param_cnt < CNT_W'(1) || param_cnt > CNT_W'(MAX_PARAMS)) begin
            return;
        end
        idx = IDX_W'(param_cnt - CNT_W'(1));
        v = 32'(params[idx]) * 32'd10 + 32'(b - CH_ZERO);
        if (v > 32'(PARAM_LIMIT)) begin
            v = 32'(PARAM_LIMIT);
        end
        params[idx] = v[PARAM_BITS-1:0];
    endfunction

    function automatic void open_param();
        if (param_cnt < CNT_W'(MAX_PARAMS)) begin
            params[IDX_W'(param_cnt)] = '0;
            param_cnt = param_cnt + CNT_W'(1);
        end else begin
            param_cnt = CNT_W'(MAX_PARAMS + 1);
        end
    endfunction

    function automatic logic is_sixel(logic [7:0] b);
        return b >= SIXEL_FIRST && b <= SIXEL_LAST;
    endfunction

    function automatic void handle_other(logic [7:0] b);
        case (b)
            CH_COLOR:  enter_state(PS_COLOR_INTRO);
            CH_REPEAT: enter_state(PS_REPEAT);
            CH_RASTER: enter_state(PS_RASTER);
            CH_REWIND: begin
                enter_state(PS_GROUND);
                emit_event(blank_event(EV_REWIND));
            end
            CH_NEWLINE: begin
                enter_state(PS_GROUND);
                emit_event(blank_event(EV_NEWLINE));
            end
            default: begin
                if (parse_state != PS_GROUND) begin
                    enter_state(PS_GROUND);
                end
                if (is_sixel(b)) begin
                    emit_render(b, PARAM_BITS'(1));
                end
            end
        endcase
    endfunction

    function automatic void parse_byte(logic k, logic [7:0] b);
        logic    digit;
        t_result r;
        digit = b >= CH_ZERO && b <= CH_NINE;
        step_events.delete();
        if (k == KIND_END) begin
            enter_state(PS_GROUND);
            emit_event(blank_event(EV_FINISHED));
        end else begin
            case (parse_state)
                PS_REPEAT: begin
                    if (digit) begin
                        add_digit(b);
                    end else if (is_sixel(b)) begin
                        if (params[0] != '0) begin
                            emit_render(b, params[0]);
                        end
                        enter_state(PS_GROUND);
                    end else begin
                        handle_other(b);
                    end
                end
                PS_COLOR_INTRO: begin
                    if (digit) begin
                        add_digit(b);
                        enter_state(PS_COLOR_PARAMS);
                    end else begin
                        handle_other(b);
                    end
                end
                PS_COLOR_PARAMS, PS_RASTER: begin
                    if (digit) begin
                        add_digit(b);
                    end else if (b == CH_SEMI) begin
                        open_param();
                    end else begin
                        handle_other(b);
                    end
                end
                default: begin
                    parse_state = PS_GROUND;
                    handle_other(b);
                end
            endcase
        end
        foreach (step_events[i]) begin
            r = step_events[i];
            r.last = (i == step_events.size() - 1);
            expected_events.insert(expected_events.size(), r);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    function automatic void compare_event();
        t_result want;
        if (expected_events.size() == 0) begin
            $error("event_res: expected none, got %0d", i_out.event_res);
            fail_total++;
            return;
        end
        want = expected_events.pop_front();
        checked_total++;
        check_field("event_res", 16'(want.event_res), 16'(i_out.event_res));
        check_field("sixel_bits", 16'(want.sixel_bits), 16'(i_out.sixel_bits));
        check_field("repeat_count", want.repeat_count, i_out.repeat_count);
        check_field("color_index", want.color_index, i_out.color_index);
        check_field("red", 16'(want.red), 16'(i_out.red));
        check_field("green", 16'(want.green), 16'(i_out.green));
        check_field("blue", 16'(want.blue), 16'(i_out.blue));
        check_field("aspect_numerator", want.aspect_numerator, i_out.aspect_numerator);
        check_field("aspect_denominator", want.aspect_denominator, i_out.aspect_denominator);
        check_field("image_width", want.image_width, i_out.image_width);
        check_field("image_height", want.image_height, i_out.image_height);
        check_field("last", 16'(want.last), 16'(i_out.last));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = PS_GROUND;
            param_cnt = '0;
            foreach (params[i]) begin
                params[i] = '0;
            end
            expected_events.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                parse_byte(i_in.kind, i_in.byte_value);
            end
            if (i_out.valid && i_out.ready) begin
                compare_event();
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// ----- sim/sixel_stream_parser_top_tb.sv -----
`timescale 1ns / 1ps

module sixel_stream_parser_top_tb;

    import sxp_pkg::*;
    import sixel_tb_pkg::*;

    localparam int RANDOM_ITEMS    = 1000;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;

    logic i_clk;
    logic i_rst_n;
    logic draining = 1'b0;
    int   fail_count;
    int   pending_events;
    int   checked_events;
    int   items_sent = 0;
    int   end_marks = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;

    sxp_in_if  in_ch ();
    sxp_out_if out_ch ();

    sixel_stream_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sixel_stream_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_events),
        .o_checked    (checked_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, one long hold-off early on, then varied styles
    initial begin
        int style;
        int span;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        repeat (300) begin
            out_ch.ready <= ($urandom_range(0, 1) == 1);
            @(posedge i_clk);
        end
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        forever begin
            style = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                case (style)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= draining || ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= draining || ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= draining || ($urandom_range(0, 9) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic k, logic [7:0] b);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 16);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= k;
        in_ch.byte_value <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
        if (k == KIND_END) begin
            end_marks++;
        end
    endtask

    task automatic send_data(logic [7:0] b);
        send_item(KIND_DATA, b);
    endtask

    task automatic send_number(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) begin
            send_data(s[i]);
        end
    endtask

    function automatic int unsigned pick_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            6, 7:    return $urandom_range(0, 999);
            8:       return $urandom_range(0, 65535);
            9:       return $urandom_range(65536, 9999999);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    task automatic send_random_sequence();
        int choice;
        int n;
        int unsigned v;
        choice = $urandom_range(0, 19);
        if (choice <= 4) begin
            n = $urandom_range(1, 8);
            repeat (n) send_data(8'($urandom_range(SIXEL_FIRST, SIXEL_LAST)));
        end else if (choice <= 7) begin
            send_data(CH_REPEAT);
            case ($urandom_range(0, 5))
                0:       send_number(0);
                1:       send_number(pick_value());
                default: send_number($urandom_range(1, 300));
            endcase
            if ($urandom_range(0, 7) != 0) begin
                send_data(8'($urandom_range(SIXEL_FIRST, SIXEL_LAST)));
            end else begin
                send_data(8'($urandom_range(0, 255)));
            end
        end else if (choice <= 9) begin
            send_data(CH_COLOR);
            send_number(pick_value());
        end else if (choice <= 12) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 7) : RGB_PARAM_COUNT;
            send_data(CH_COLOR);
            send_number(pick_value());
            for (int i = 1; i < n; i++) begin
                send_data(CH_SEMI);
                if (i == 1) begin
                    v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : COLOR_SPACE_RGB;
                end else begin
                    v = ($urandom_range(0, 5) == 0) ? pick_value() : $urandom_range(0, 100);
                end
                if ($urandom_range(0, 15) != 0) begin
                    send_number(v);
                end
            end
        end else if (choice <= 14) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : RASTER_PARAM_COUNT;
            send_data(CH_RASTER);
            for (int i = 0; i < n; i++) begin
                if (i > 0) begin
                    send_data(CH_SEMI);
                end
                if ($urandom_range(0, 15) != 0) begin
                    send_number(pick_value());
                end
            end
        end else if (choice == 15) begin
            send_data(CH_REWIND);
        end else if (choice == 16) begin
            send_data(CH_NEWLINE);
        end else if (choice == 17) begin
            send_item(KIND_END, 8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) send_data(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_DATA;
        in_ch.byte_value <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes and plain sixels
        send_data(8'h00);
        send_data(SIXEL_FIRST);
        send_data(SIXEL_LAST);
        send_data(8'hFF);
        // zero repeat count
        send_data(CH_REPEAT);
        send_number(0);
        send_data(SIXEL_LAST);
        // color select closed by rewind
        send_data(CH_COLOR);
        send_number(5);
        send_data(CH_REWIND);
        // RGB define at full and zero scale, closed by newline
        send_data(CH_COLOR);
        send_number(1);
        send_data(CH_SEMI);
        send_number(COLOR_SPACE_RGB);
        send_data(CH_SEMI);
        send_number(100);
        send_data(CH_SEMI);
        send_number(0);
        send_data(CH_SEMI);
        send_number(99);
        send_data(CH_NEWLINE);
        send_item(KIND_END, 8'hA5);

        while (items_sent < RANDOM_ITEMS) begin
            send_random_sequence();
        end
        send_item(KIND_END, 8'($urandom_range(0, 255)));

        in_ch.valid <= 1'b0;
        draining <= 1'b1;
        @(posedge i_clk);
        while (pending_events != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d input transactions sent (%0d end marks), %0d events checked",
                 items_sent, end_marks, checked_events);
        $display("tb: covered sixel runs, repeats, color select/define, raster, rewind, "
                 , "newline and noise bytes under random stalls and one long hold-off");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/sxp_pkg.sv
design/sxp_if.sv
design/sxp_parser.sv
design/sxp_result_fifo.sv
design/sixel_stream_parser_top.sv
sim/sixel_tb_pkg.sv
sim/sixel_stream_parser_checker.sv
sim/sixel_stream_parser_top_tb.sv
